FILE: sv/bdrwl_pkg.sv
package bdrwl_pkg;

  localparam int unsigned NUM_BINS  = 8;
  localparam int unsigned BIN_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned THR_W     = 16;

  localparam logic [9:0]        WINDOW_SCALE  = 10'd1000;
  localparam logic [THR_W-1:0]  THR_RESET     = 16'd13107;
  localparam logic [CNT_W-1:0]  BIN_DUR_RESET = 32'd10;
  localparam logic [BIN_W-1:0]  LAST_BIN      = BIN_W'(NUM_BINS - 1);

  typedef enum logic [1:0] {
    ACT_SENT = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_INIT = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_BIN_DUR   = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEND_RD,
    ST_SEND_WR,
    ST_ACK_TIME,
    ST_ACK_RD,
    ST_ACK_WR,
    ST_SUM,
    ST_SUM_END,
    ST_MUL,
    ST_CMP,
    ST_FIN
  } state_e;

endpackage

FILE: sv/binned_delivery_ratio_window_limiter_top.sv
// Binned delivery-ratio window limiter.
//
// Input channel (in_valid_i / in_stall_o) carries one event word: action,
// byte_count, time_now and initial_window. A word is taken when in_valid_i
// is high and in_stall_o is low. Output channel (out_valid_o / out_stall_i)
// returns exactly one word per event: the window after the event and
// exit_taken.
//
// Work is done by a small sequencer around one pair of bin arrays with a
// single registered read port. A send reads and then writes its bin. An ack
// updates the time and current bin, reads and writes that bin, then the sum
// walks one bin per cycle from bin 0 through the current bin, followed by one
// multiply step and one compare step.
// in_stall_o stays high from acceptance until the result is loaded into the
// output register. The output register lets a new event be taken while the
// previous result is still stalled downstream; a finished event waits in its
// final step until the output register is free. Reset clears all bins
// (per-bin valid bits), the deadline, the window and the output valid;
// configuration registers return to threshold 13107 and bin duration 10.
module binned_delivery_ratio_window_limiter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bdrwl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bdrwl_pkg::CFG_W-1:0]       cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        action_i,
  input  logic [bdrwl_pkg::CNT_W-1:0]       byte_count_i,
  input  logic [bdrwl_pkg::TIME_W-1:0]      time_now_i,
  input  logic [bdrwl_pkg::CNT_W-1:0]       initial_window_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bdrwl_pkg::CNT_W-1:0]       window_o,
  output logic                              exit_taken_o
);

  localparam int unsigned NB = bdrwl_pkg::NUM_BINS;
  localparam int unsigned BW = bdrwl_pkg::BIN_W;
  localparam int unsigned CW = bdrwl_pkg::CNT_W;
  localparam int unsigned TW = bdrwl_pkg::TIME_W;
  localparam int unsigned PW = bdrwl_pkg::THR_W + bdrwl_pkg::CNT_W;

  // configuration registers
  logic [bdrwl_pkg::THR_W-1:0] thr_q;
  logic [CW-1:0]               bin_dur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= bdrwl_pkg::THR_RESET;
      bin_dur_q <= bdrwl_pkg::BIN_DUR_RESET;
    end else if (cfg_we_i) begin
      case (bdrwl_pkg::cfg_idx_e'(cfg_index_i))
        bdrwl_pkg::CFG_THRESHOLD: thr_q     <= cfg_data_i[bdrwl_pkg::THR_W-1:0];
        bdrwl_pkg::CFG_BIN_DUR:   bin_dur_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  bdrwl_pkg::state_e state_q, state_d;

  logic [1:0]    action_q;
  logic [CW-1:0] bytes_q;
  logic [TW-1:0] now_q;
  logic [CW-1:0] initw_q;

  // bin store: flops with per-bin valid, one registered read port
  logic [CW-1:0] sent_mem [NB];
  logic [CW-1:0] del_mem  [NB];
  logic [NB-1:0] bin_vld_q;
  logic [BW-1:0] rd_addr;
  logic [CW-1:0] sent_rd_q, del_rd_q;

  logic [BW-1:0] cur_q, cnt_q, prev_q;
  logic          pend_q;
  logic [TW-1:0] dl_q;
  logic [CW-1:0] win_q;
  logic [CW-1:0] dcur_q;
  logic [CW-1:0] s_acc_q, d_acc_q;
  logic [CW-1:0] diff_q;
  logic          gt_q;
  logic [PW-1:0] prod_q;
  logic          exit_q;

  logic          out_free;
  logic [TW-1:0] dl_eff;
  logic          advance;
  logic [BW-1:0] cur_inc;
  logic [CW-1:0] s_next, d_next;

  assign in_stall_o = (state_q != bdrwl_pkg::ST_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;

  assign dl_eff  = (dl_q == '0) ? now_q : dl_q;
  assign advance = now_q > dl_eff;
  assign cur_inc = (cur_q == bdrwl_pkg::LAST_BIN) ? '0 : cur_q + BW'(1);

  // pending read lands in the cycle after its address
  assign s_next = s_acc_q + sent_rd_q;
  assign d_next = (prev_q != cur_q) ? d_acc_q + del_rd_q : d_acc_q;

  always_comb begin
    state_d = state_q;
    rd_addr = cur_q;
    case (state_q)
      bdrwl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (bdrwl_pkg::action_e'(action_i))
            bdrwl_pkg::ACT_SENT: state_d = bdrwl_pkg::ST_SEND_RD;
            bdrwl_pkg::ACT_ACK:  state_d = bdrwl_pkg::ST_ACK_TIME;
            bdrwl_pkg::ACT_INIT: state_d = bdrwl_pkg::ST_INIT;
            default:             state_d = bdrwl_pkg::ST_FIN;
          endcase
        end
      end
      bdrwl_pkg::ST_INIT:     state_d = bdrwl_pkg::ST_FIN;
      bdrwl_pkg::ST_SEND_RD:  state_d = bdrwl_pkg::ST_SEND_WR;
      bdrwl_pkg::ST_SEND_WR:  state_d = bdrwl_pkg::ST_FIN;
      bdrwl_pkg::ST_ACK_TIME: state_d = bdrwl_pkg::ST_ACK_RD;
      bdrwl_pkg::ST_ACK_RD:   state_d = bdrwl_pkg::ST_ACK_WR;
      bdrwl_pkg::ST_ACK_WR:   state_d = bdrwl_pkg::ST_SUM;
      bdrwl_pkg::ST_SUM: begin
        rd_addr = cnt_q;
        if (cnt_q == cur_q) state_d = bdrwl_pkg::ST_SUM_END;
      end
      bdrwl_pkg::ST_SUM_END:  state_d = bdrwl_pkg::ST_MUL;
      bdrwl_pkg::ST_MUL:      state_d = bdrwl_pkg::ST_CMP;
      bdrwl_pkg::ST_CMP:      state_d = bdrwl_pkg::ST_FIN;
      bdrwl_pkg::ST_FIN: begin
        if (out_free) state_d = bdrwl_pkg::ST_IDLE;
      end
      default:                state_d = bdrwl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdrwl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // read port; an invalid bin reads as zero
  always_ff @(posedge clk_i) begin
    sent_rd_q <= bin_vld_q[rd_addr] ? sent_mem[rd_addr] : '0;
    del_rd_q  <= bin_vld_q[rd_addr] ? del_mem[rd_addr]  : '0;
  end

  // write port: send updates sent count, ack updates delivered count;
  // the other count of a bin that was invalid is zeroed on its first write
  always_ff @(posedge clk_i) begin
    if (state_q == bdrwl_pkg::ST_SEND_WR) begin
      sent_mem[cur_q] <= sent_rd_q + bytes_q;
      if (!bin_vld_q[cur_q]) del_mem[cur_q] <= '0;
    end else if (state_q == bdrwl_pkg::ST_ACK_WR) begin
      del_mem[cur_q] <= del_rd_q + bytes_q;
      if (!bin_vld_q[cur_q]) sent_mem[cur_q] <= '0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      cur_q     <= '0;
      dl_q      <= '0;
      win_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        bdrwl_pkg::ST_INIT: begin
          bin_vld_q <= '0;
          cur_q     <= '0;
          win_q     <= initw_q;
          dl_q      <= now_q + TW'(bin_dur_q);
        end
        bdrwl_pkg::ST_SEND_WR: bin_vld_q[cur_q] <= 1'b1;
        bdrwl_pkg::ST_ACK_TIME: begin
          if (advance) begin
            dl_q               <= dl_eff + TW'(bin_dur_q);
            cur_q              <= cur_inc;
            bin_vld_q[cur_inc] <= 1'b0;
          end else begin
            dl_q <= dl_eff;
          end
        end
        bdrwl_pkg::ST_ACK_WR: bin_vld_q[cur_q] <= 1'b1;
        bdrwl_pkg::ST_CMP: begin
          if (gt_q && ({diff_q, 16'h0000} > prod_q)) begin
            win_q <= CW'(dcur_q * bdrwl_pkg::WINDOW_SCALE);
          end
        end
        default: ;
      endcase

      if (state_q == bdrwl_pkg::ST_FIN && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      bdrwl_pkg::ST_IDLE: begin
        action_q <= action_i;
        bytes_q  <= byte_count_i;
        now_q    <= time_now_i;
        initw_q  <= initial_window_i;
        exit_q   <= 1'b0;
      end
      bdrwl_pkg::ST_ACK_WR: begin
        dcur_q  <= del_rd_q + bytes_q;
        cnt_q   <= '0;
        pend_q  <= 1'b0;
        s_acc_q <= '0;
        d_acc_q <= '0;
      end
      bdrwl_pkg::ST_SUM: begin
        if (pend_q) begin
          s_acc_q <= s_next;
          d_acc_q <= d_next;
        end
        prev_q <= cnt_q;
        pend_q <= 1'b1;
        cnt_q  <= cnt_q + BW'(1);
      end
      bdrwl_pkg::ST_SUM_END: begin
        s_acc_q <= s_next;
        d_acc_q <= d_next;
      end
      bdrwl_pkg::ST_MUL: begin
        // S > D also rules out S == 0
        gt_q   <= s_acc_q > d_acc_q;
        diff_q <= s_acc_q - d_acc_q;
        prod_q <= thr_q * s_acc_q;
      end
      bdrwl_pkg::ST_CMP: exit_q <= gt_q && ({diff_q, 16'h0000} > prod_q);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == bdrwl_pkg::ST_FIN && out_free) begin
      window_o     <= win_q;
      exit_taken_o <= exit_q && (action_q == 2'(bdrwl_pkg::ACT_ACK));
    end
  end

endmodule

FILE: sv/bdrwl_checker.sv
module bdrwl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] window_o,
  input logic        exit_taken_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(window_o) && $stable(exit_taken_o))
    else $error("output word changed under stall");

  // block is busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while idle after accept");

  // a result only appears at the end of a busy period
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work");

endmodule

bind binned_delivery_ratio_window_limiter_top bdrwl_checker u_bdrwl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_o     (window_o),
  .exit_taken_o (exit_taken_o)
);
